// ===== design/aes128_key_expansion_assert.svh =====
// Assertion macros for the key expansion block
`ifndef AES128_KEY_EXPANSION_ASSERT_SVH
`define AES128_KEY_EXPANSION_ASSERT_SVH

`ifndef SYNTH

`define KE_ASSERT_SAME(label, clk, rst_n, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
        else $error(msg);

`define KE_ASSERT_NEXT(label, clk, rst_n, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error(msg);

`else

`define KE_ASSERT_SAME(label, clk, rst_n, cond, conseq, msg)

`define KE_ASSERT_NEXT(label, clk, rst_n, cond, conseq, msg)

`endif

`endif

// ===== design/aes128ke_pkg.sv =====
package aes128ke_pkg;

    localparam int unsigned WORD_W      = 32;
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned INDEX_W     = 6;
    localparam int unsigned KEY_WORDS   = 4;
    localparam int unsigned TOTAL_WORDS = 44;

    localparam logic [INDEX_W-1:0] LAST_INDEX = INDEX_W'(TOTAL_WORDS - 1);
    localparam logic [1:0]         LAST_KEY_SLOT = 2'(KEY_WORDS - 1);

    localparam logic [BYTE_W-1:0] RCON_FIRST = 8'h01;
    localparam logic [BYTE_W-1:0] RCON_POLY  = 8'h1b;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [BYTE_W-1:0] byte_t;

    typedef struct packed {
        logic  use_sub;
        byte_t rcon;
    } ke_ctrl_t;

    localparam byte_t SBOX [0:255] = '{
        8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
        8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
        8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
        8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
        8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
        8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
        8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
        8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
        8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
        8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
        8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
        8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
        8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
        8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
        8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
        8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
        8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
        8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
        8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
        8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
        8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
        8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
        8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
        8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
        8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
        8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
        8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
        8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
        8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
        8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
        8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
        8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
    };

    function automatic byte_t xtime(input byte_t b);
        byte_t r;
        r = {b[BYTE_W-2:0], 1'b0};
        if (b[BYTE_W-1])
        begin
            r = r ^ RCON_POLY;
        end
        return r;
    endfunction

endpackage

// ===== design/aes128ke_word_unit.sv =====
module aes128ke_word_unit (
    input  aes128ke_pkg::word_t    oldest_word,
    input  aes128ke_pkg::word_t    newest_word,
    input  aes128ke_pkg::ke_ctrl_t ctrl,
    output aes128ke_pkg::word_t    next_word
);

    aes128ke_pkg::word_t rot_word;
    aes128ke_pkg::word_t sub_word;
    aes128ke_pkg::word_t mixed_word;

    assign rot_word = {newest_word[23:0], newest_word[31:24]};

    always_comb
    begin
        for (int b = 0; b < 4; b++)
        begin
            sub_word[b*8 +: 8] = aes128ke_pkg::SBOX[rot_word[b*8 +: 8]];
        end
    end

    // apply the S-box path on the first word of each round key
    assign mixed_word = ctrl.use_sub ? (sub_word ^ {ctrl.rcon, 24'h000000}) : newest_word;
    assign next_word  = mixed_word ^ oldest_word;

endmodule

// ===== design/aes128_key_expansion.sv =====
// Channel  | Ports                             | Handshake
// ---------+-----------------------------------+------------------------------
// key in   | cipher_key_word                   | transfer when start && !busy
// words out| word_index, expanded_word,        | transfer on every strobe cycle
//          | last_word                         |
//
// The first three key words give no result.
// The fourth key word starts a run with busy high; the single
// word unit produces one expanded word per cycle; W0 leaves through the
// output register first and W43 (last_word high) last, as busy falls.
// Reset clears the four-word window, the key word count and the run state.
// The receiver cannot stall; one word is shown per strobe cycle.
module aes128_key_expansion (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] cipher_key_word,
    output logic        strobe,
    output logic [5:0]  word_index,
    output logic [31:0] expanded_word,
    output logic        last_word
);

`include "aes128_key_expansion_assert.svh"

    typedef enum logic {
        ST_LOAD,
        ST_RUN
    } state_t;

    state_t                             state_reg;
    logic [1:0]                         loaded_reg;
    logic [aes128ke_pkg::INDEX_W-1:0]   count_reg;
    aes128ke_pkg::byte_t                rcon_reg;
    aes128ke_pkg::word_t                window_reg [4];
    logic                               strobe_reg;
    logic [aes128ke_pkg::INDEX_W-1:0]   index_reg;
    aes128ke_pkg::word_t                word_reg;
    logic                               last_reg;

    logic                               accept;
    aes128ke_pkg::ke_ctrl_t             ctrl;
    aes128ke_pkg::word_t                next_word;

    assign accept       = start && (state_reg == ST_LOAD);
    assign ctrl.use_sub = (count_reg[1:0] == 2'b00);
    assign ctrl.rcon    = rcon_reg;

    aes128ke_word_unit u_word_unit (
        .oldest_word (window_reg[0]),
        .newest_word (window_reg[3]),
        .ctrl        (ctrl),
        .next_word   (next_word)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_LOAD;
            loaded_reg <= 2'd0;
            count_reg  <= '0;
            rcon_reg   <= aes128ke_pkg::RCON_FIRST;
            strobe_reg <= 1'b0;
            index_reg  <= '0;
            word_reg   <= '0;
            last_reg   <= 1'b0;
            for (int k = 0; k < 4; k++)
            begin
                window_reg[k] <= '0;
            end
        end
        else
        begin
            strobe_reg <= 1'b0;
            index_reg  <= count_reg;
            word_reg   <= window_reg[0];
            last_reg   <= (count_reg == aes128ke_pkg::LAST_INDEX);
            unique case (state_reg)
                ST_LOAD:
                begin
                    if (accept)
                    begin
                        window_reg[loaded_reg] <= cipher_key_word;
                        loaded_reg             <= loaded_reg + 2'd1;
                        if (loaded_reg == aes128ke_pkg::LAST_KEY_SLOT)
                        begin
                            state_reg <= ST_RUN;
                            count_reg <= '0;
                            rcon_reg  <= aes128ke_pkg::RCON_FIRST;
                        end
                    end
                end
                ST_RUN:
                begin
                    // emit the oldest word, shift in the next one
                    strobe_reg    <= 1'b1;
                    window_reg[0] <= window_reg[1];
                    window_reg[1] <= window_reg[2];
                    window_reg[2] <= window_reg[3];
                    window_reg[3] <= next_word;
                    if (ctrl.use_sub)
                    begin
                        rcon_reg <= aes128ke_pkg::xtime(rcon_reg);
                    end
                    count_reg <= count_reg + 1'b1;
                    if (count_reg == aes128ke_pkg::LAST_INDEX)
                    begin
                        state_reg <= ST_LOAD;
                    end
                end
                default:
                begin
                    state_reg <= ST_LOAD;
                end
            endcase
        end
    end

    assign busy          = (state_reg == ST_RUN);
    assign strobe        = strobe_reg;
    assign word_index    = index_reg;
    assign expanded_word = word_reg;
    assign last_word     = last_reg;

    `KE_ASSERT_SAME(a_last_ends_run, clk, rst_n, strobe && last_word, !busy, "run still busy at last word")
    `KE_ASSERT_SAME(a_mid_run_busy, clk, rst_n, strobe && !last_word, busy, "word shown outside a run")
    `KE_ASSERT_NEXT(a_index_steps, clk, rst_n, strobe && !last_word, strobe && (word_index == $past(word_index) + 6'd1), "word index did not advance")
    `KE_ASSERT_NEXT(a_fourth_starts, clk, rst_n, accept && (loaded_reg == aes128ke_pkg::LAST_KEY_SLOT), busy && strobe == 1'b0 && count_reg == 6'd0, "fourth key word did not start a run")

endmodule
